// ===== hdl/hlc_pkg.sv =====
// Shared types and constants for the hop lock / LBT controller.
package hlc_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_MODE          = 3'd0;
  localparam logic [2:0] CFG_LOCKED_PERIOD = 3'd1;
  localparam logic [2:0] CFG_UNLOCK_PERIOD = 3'd2;
  localparam logic [2:0] CFG_FIRST_PERIOD  = 3'd3;
  localparam logic [2:0] CFG_LOCK_TIMEOUT  = 3'd4;
  localparam logic [2:0] CFG_LBT_LIMIT     = 3'd5;
  localparam logic [2:0] CFG_PAIR_LIMIT    = 3'd6;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 24;

  // Operating modes
  localparam logic [2:0] MODE_OFF       = 3'd0;
  localparam logic [2:0] MODE_NORMAL    = 3'd1;
  localparam logic [2:0] MODE_JAM       = 3'd2;
  localparam logic [2:0] MODE_PAIR_MST  = 3'd3;
  localparam logic [2:0] MODE_PAIR_SLV  = 3'd4;

  // Reset values of registers that are not zero
  localparam logic [7:0] LOCK_TIMEOUT_RST = 8'd10;
  localparam logic [7:0] PAIR_LIMIT_RST   = 8'hC4;  // -60 dBm

  // Event codes
  typedef enum logic [1:0] {
    ACT_TIMER   = 2'd0,
    ACT_RSSI    = 2'd1,
    ACT_CRC_OK  = 2'd2,
    ACT_CRC_ERR = 2'd3
  } action_e;

  // Radio commands
  typedef enum logic [2:0] {
    RC_NONE    = 3'd0,
    RC_RX_EN   = 3'd1,
    RC_TX_DATA = 3'd2,
    RC_TX_JAM  = 3'd3,
    RC_TX_PAIR = 3'd4,
    RC_STOP    = 3'd5
  } radio_cmd_e;

  // Lock state codes as reported
  localparam logic [1:0] LS_UNLOCKED = 2'd0;
  localparam logic [1:0] LS_FIRST    = 2'd1;
  localparam logic [1:0] LS_LOCKED   = 2'd2;

  // Hop lock state machine
  typedef enum logic [2:0] {
    PH_UNLOCKED = 3'b001,
    PH_FIRST    = 3'b010,
    PH_LOCKED   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [1:0]  action;
    logic        tx_queue_nonempty;
    logic        rx_queue_full;
    logic [6:0]  rssi_sample;
    logic [31:0] rx_frame_number;
  } in_t;

  typedef struct packed {
    logic [6:0]  channel;
    logic [2:0]  radio_command;
    logic [23:0] reload_period;
    logic        period_reload;
    logic [1:0]  lock_state;
    logic [31:0] tx_frame_number;
    logic [31:0] tx_count;
    logic [31:0] lbt_skip_count;
    logic [31:0] rx_count;
    logic [31:0] rx_lost_count;
    logic [31:0] rx_bad_crc_count;
    logic [31:0] rx_discard_count;
  } out_t;

  // Configuration as seen by the core
  typedef struct packed {
    logic [2:0]        mode;
    logic [23:0]       locked_period_us;
    logic [23:0]       unlocked_period_us;
    logic [23:0]       first_lock_period_us;
    logic [7:0]        lock_timeout_periods;
    logic signed [7:0] lbt_limit_dbm;
    logic signed [7:0] pairing_limit_dbm;
  } cfg_t;

  // Side effects of a mode register write
  typedef struct packed {
    logic strobe;
    logic nonzero;
  } mode_wr_t;

endpackage

// ===== hdl/hop_lock_lbt_controller.sv =====
// Top level of the hop lock / LBT controller: config registers, core and result buffer.
// A result is written into the result buffer when its input transaction is accepted.
// Throughput: one event per cycle while the result buffer has room; the core computes all next state combinationally.
// A two-entry result buffer holds results; input ready drops only when both are full.
// Reset (rst_ni low, asynchronous): state, counters and buffer clear; registers take
// their defaults (timeout 10 periods, pairing limit -60 dBm, all others zero).
module hop_lock_lbt_controller #(
  parameter int unsigned CHANNEL_COUNT = 79,
  parameter int unsigned HOP_STEP      = 19
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  hlc_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output hlc_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [hlc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [hlc_pkg::CfgDataWidth-1:0]    cfg_wdata_i
);

  hlc_pkg::cfg_t     cfg_q, cfg_d;
  hlc_pkg::mode_wr_t mode_wr;
  hlc_pkg::out_t     res;
  logic              buf_full;
  logic              fire;

  assign in_ready_o = !buf_full;
  assign fire       = in_valid_i && in_ready_o;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        hlc_pkg::CFG_MODE:          cfg_d.mode                 = cfg_wdata_i[2:0];
        hlc_pkg::CFG_LOCKED_PERIOD: cfg_d.locked_period_us     = cfg_wdata_i;
        hlc_pkg::CFG_UNLOCK_PERIOD: cfg_d.unlocked_period_us   = cfg_wdata_i;
        hlc_pkg::CFG_FIRST_PERIOD:  cfg_d.first_lock_period_us = cfg_wdata_i;
        hlc_pkg::CFG_LOCK_TIMEOUT:  cfg_d.lock_timeout_periods = cfg_wdata_i[7:0];
        hlc_pkg::CFG_LBT_LIMIT:     cfg_d.lbt_limit_dbm        = $signed(cfg_wdata_i[7:0]);
        hlc_pkg::CFG_PAIR_LIMIT:    cfg_d.pairing_limit_dbm    = $signed(cfg_wdata_i[7:0]);
        default: begin
        end
      endcase
    end
  end

  assign mode_wr.strobe  = cfg_we_i && (cfg_idx_i == hlc_pkg::CFG_MODE);
  assign mode_wr.nonzero = (cfg_wdata_i[2:0] != hlc_pkg::MODE_OFF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode                 <= hlc_pkg::MODE_OFF;
      cfg_q.locked_period_us     <= '0;
      cfg_q.unlocked_period_us   <= '0;
      cfg_q.first_lock_period_us <= '0;
      cfg_q.lock_timeout_periods <= hlc_pkg::LOCK_TIMEOUT_RST;
      cfg_q.lbt_limit_dbm        <= '0;
      cfg_q.pairing_limit_dbm    <= $signed(hlc_pkg::PAIR_LIMIT_RST);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hlc_core #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .HOP_STEP      (HOP_STEP)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_i      (in_data_i),
    .cfg_i     (cfg_q),
    .mode_wr_i (mode_wr),
    .res_o     (res)
  );

  hlc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

// ===== hdl/hlc_core.sv =====
// Hop lock state machine, LBT request, frame numbers and statistics.
module hlc_core #(
  parameter int unsigned CHANNEL_COUNT = 79,
  parameter int unsigned HOP_STEP      = 19
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  hlc_pkg::in_t      in_i,
  input  hlc_pkg::cfg_t     cfg_i,
  input  hlc_pkg::mode_wr_t mode_wr_i,
  output hlc_pkg::out_t     res_o
);

  localparam int unsigned StepMod = HOP_STEP % CHANNEL_COUNT;
  localparam logic [7:0]  StepW   = 8'(StepMod);
  localparam logic [7:0]  CountW  = 8'(CHANNEL_COUNT);

  hlc_pkg::phase_e     phase_q, phase_d;
  logic [7:0]          countdown_q, countdown_d;
  logic [6:0]          chan_q, chan_d;
  logic                sw_q, sw_d;
  logic                halted_q, halted_d;
  logic [31:0]         txfc_q, txfc_d;
  logic [31:0]         last_q, last_d;
  logic [31:0]         tx_cnt_q, tx_cnt_d;
  logic [31:0]         skip_cnt_q, skip_cnt_d;
  logic [31:0]         rx_cnt_q, rx_cnt_d;
  logic [31:0]         lost_cnt_q, lost_cnt_d;
  logic [31:0]         bad_cnt_q, bad_cnt_d;
  logic [31:0]         disc_cnt_q, disc_cnt_d;

  hlc_pkg::radio_cmd_e cmd;
  logic [23:0]         period;
  logic                reload;
  logic                active;
  logic [7:0]          hop_sum;
  logic [6:0]          hop_chan;
  logic signed [8:0]   level;
  logic                below_lbt;
  logic                above_pair;
  logic [1:0]          lock_code;

  // Next hop channel: channel stays below the count, so one subtract wraps it
  assign hop_sum  = {1'b0, chan_q} + StepW;
  assign hop_chan = (hop_sum >= CountW) ? 7'(hop_sum - CountW) : hop_sum[6:0];

  // Channel level in dBm and limit compares
  assign level      = 9'sd0 - $signed({2'b00, in_i.rssi_sample});
  assign below_lbt  = level < $signed({cfg_i.lbt_limit_dbm[7], cfg_i.lbt_limit_dbm});
  assign above_pair = level > $signed({cfg_i.pairing_limit_dbm[7], cfg_i.pairing_limit_dbm});

  assign active = (cfg_i.mode >= hlc_pkg::MODE_NORMAL) &&
                  (cfg_i.mode <= hlc_pkg::MODE_PAIR_SLV) && !halted_q;

  // Event processing
  always_comb begin
    phase_d     = phase_q;
    countdown_d = countdown_q;
    chan_d      = chan_q;
    sw_d        = sw_q;
    halted_d    = halted_q;
    txfc_d      = txfc_q;
    last_d      = last_q;
    tx_cnt_d    = tx_cnt_q;
    skip_cnt_d  = skip_cnt_q;
    rx_cnt_d    = rx_cnt_q;
    lost_cnt_d  = lost_cnt_q;
    bad_cnt_d   = bad_cnt_q;
    disc_cnt_d  = disc_cnt_q;
    cmd         = hlc_pkg::RC_NONE;
    period      = '0;
    reload      = 1'b0;

    if (fire_i && active) begin
      case (hlc_pkg::action_e'(in_i.action))
        hlc_pkg::ACT_TIMER: begin
          chan_d = hop_chan;
          if (cfg_i.mode == hlc_pkg::MODE_NORMAL) begin
            if (phase_q == hlc_pkg::PH_FIRST) begin
              phase_d     = hlc_pkg::PH_LOCKED;
              countdown_d = cfg_i.lock_timeout_periods;
              period      = cfg_i.locked_period_us;
              reload      = 1'b1;
            end else if (phase_q == hlc_pkg::PH_LOCKED) begin
              if (countdown_q <= 8'd1) begin
                countdown_d = '0;
                phase_d     = hlc_pkg::PH_UNLOCKED;
                period      = cfg_i.unlocked_period_us;
                reload      = 1'b1;
              end else begin
                countdown_d = countdown_q - 8'd1;
              end
            end
            if (in_i.tx_queue_nonempty) begin
              sw_d = 1'b1;
            end
            cmd = hlc_pkg::RC_RX_EN;
          end else if (cfg_i.mode == hlc_pkg::MODE_PAIR_SLV) begin
            cmd = hlc_pkg::RC_RX_EN;
          end else begin
            // jammer and pairing master lock on their own timing
            phase_d     = hlc_pkg::PH_LOCKED;
            countdown_d = cfg_i.lock_timeout_periods;
            period      = cfg_i.locked_period_us;
            reload      = 1'b1;
            cmd = (cfg_i.mode == hlc_pkg::MODE_JAM) ? hlc_pkg::RC_TX_JAM
                                                    : hlc_pkg::RC_TX_PAIR;
          end
        end
        hlc_pkg::ACT_RSSI: begin
          if (sw_q) begin
            sw_d = 1'b0;
            cmd  = hlc_pkg::RC_STOP;
            if (below_lbt) begin
              if (in_i.tx_queue_nonempty) begin
                txfc_d      = txfc_q + 32'd1;
                tx_cnt_d    = tx_cnt_q + 32'd1;
                phase_d     = hlc_pkg::PH_LOCKED;
                countdown_d = cfg_i.lock_timeout_periods;
                period      = cfg_i.locked_period_us;
                reload      = 1'b1;
                cmd         = hlc_pkg::RC_TX_DATA;
              end
            end else begin
              skip_cnt_d = skip_cnt_q + 32'd1;
            end
          end
        end
        hlc_pkg::ACT_CRC_OK: begin
          if (cfg_i.mode == hlc_pkg::MODE_PAIR_SLV) begin
            if ((in_i.rssi_sample != 7'd0) && above_pair) begin
              halted_d = 1'b1;
              cmd      = hlc_pkg::RC_STOP;
            end
          end else if (cfg_i.mode == hlc_pkg::MODE_NORMAL) begin
            phase_d    = hlc_pkg::PH_FIRST;
            period     = cfg_i.first_lock_period_us;
            reload     = 1'b1;
            lost_cnt_d = lost_cnt_q + in_i.rx_frame_number - last_q - 32'd1;
            last_d     = in_i.rx_frame_number;
            rx_cnt_d   = rx_cnt_q + 32'd1;
            if (in_i.rx_queue_full) begin
              disc_cnt_d = disc_cnt_q + 32'd1;
            end
          end
        end
        hlc_pkg::ACT_CRC_ERR: begin
          bad_cnt_d = bad_cnt_q + 32'd1;
        end
        default: begin
        end
      endcase
    end

    // Mode write clears a halt and, for any mode but off, restarts unlocked
    if (mode_wr_i.strobe) begin
      halted_d = 1'b0;
      if (mode_wr_i.nonzero) begin
        phase_d = hlc_pkg::PH_UNLOCKED;
      end
    end
  end

  // Reported lock state
  always_comb begin
    case (phase_d)
      hlc_pkg::PH_FIRST:  lock_code = hlc_pkg::LS_FIRST;
      hlc_pkg::PH_LOCKED: lock_code = hlc_pkg::LS_LOCKED;
      default:            lock_code = hlc_pkg::LS_UNLOCKED;
    endcase
  end

  // Result for the current transaction
  always_comb begin
    res_o.channel          = chan_d;
    res_o.radio_command    = cmd;
    res_o.reload_period    = period;
    res_o.period_reload    = reload;
    res_o.lock_state       = lock_code;
    res_o.tx_frame_number  = txfc_d;
    res_o.tx_count         = tx_cnt_d;
    res_o.lbt_skip_count   = skip_cnt_d;
    res_o.rx_count         = rx_cnt_d;
    res_o.rx_lost_count    = lost_cnt_d;
    res_o.rx_bad_crc_count = bad_cnt_d;
    res_o.rx_discard_count = disc_cnt_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hlc_pkg::PH_UNLOCKED;
      countdown_q <= '0;
      chan_q      <= '0;
      sw_q        <= 1'b0;
      halted_q    <= 1'b0;
      txfc_q      <= '0;
      last_q      <= '0;
      tx_cnt_q    <= '0;
      skip_cnt_q  <= '0;
      rx_cnt_q    <= '0;
      lost_cnt_q  <= '0;
      bad_cnt_q   <= '0;
      disc_cnt_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      countdown_q <= countdown_d;
      chan_q      <= chan_d;
      sw_q        <= sw_d;
      halted_q    <= halted_d;
      txfc_q      <= txfc_d;
      last_q      <= last_d;
      tx_cnt_q    <= tx_cnt_d;
      skip_cnt_q  <= skip_cnt_d;
      rx_cnt_q    <= rx_cnt_d;
      lost_cnt_q  <= lost_cnt_d;
      bad_cnt_q   <= bad_cnt_d;
      disc_cnt_q  <= disc_cnt_d;
    end
  end

endmodule

// ===== hdl/hlc_out_buf.sv =====
// Two-entry result buffer that decouples the core from output backpressure.
module hlc_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hlc_pkg::out_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          ready_i,
  output hlc_pkg::out_t data_o
);

  hlc_pkg::out_t mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the hop lock / LBT controller: directed event cases, then random event streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ChanCount   = 79;
  localparam int unsigned HopStep     = 19;
  localparam int unsigned PhaseEvents = 90;
  localparam int unsigned PhaseCount  = 12;
  // The limit stays well above the slowest correct run
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned PrintCap    = 100;

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  hlc_pkg::in_t                     in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  hlc_pkg::out_t                    out_data;
  logic                             cfg_we    = 1'b0;
  logic [hlc_pkg::CfgIdxWidth-1:0]  cfg_idx   = '0;
  logic [hlc_pkg::CfgDataWidth-1:0] cfg_wdata = '0;

  hop_lock_lbt_controller u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Register shadow
  logic [2:0]        m_mode       = hlc_pkg::MODE_OFF;
  logic [23:0]       m_locked_p   = '0;
  logic [23:0]       m_unlocked_p = '0;
  logic [23:0]       m_first_p    = '0;
  logic [7:0]        m_timeout    = hlc_pkg::LOCK_TIMEOUT_RST;
  logic signed [7:0] m_lbt_lim    = '0;
  logic signed [7:0] m_pair_lim   = hlc_pkg::PAIR_LIMIT_RST;

  // Controller state shadow
  logic [1:0]  m_phase     = hlc_pkg::LS_UNLOCKED;
  logic [7:0]  m_countdown = '0;
  logic [6:0]  m_chan      = '0;
  logic        m_lbt_req   = 1'b0;
  logic        m_halted    = 1'b0;
  logic [31:0] m_tx_frame  = '0;
  logic [31:0] m_last_rx   = '0;
  logic [31:0] m_tx_cnt    = '0;
  logic [31:0] m_skip_cnt  = '0;
  logic [31:0] m_rx_cnt    = '0;
  logic [31:0] m_lost_cnt  = '0;
  logic [31:0] m_bad_cnt   = '0;
  logic [31:0] m_disc_cnt  = '0;
  logic [23:0] m_period;
  logic        m_reload;

  hlc_pkg::out_t status_fifo [$];

  bit offering = 1'b0;
  bit cfg_on   = 1'b0;
  bit calm     = 1'b0;
  int rx_hold  = 0;
  int errors   = 0;
  int checked  = 0;
  int sent     = 0;
  int cycles   = 0;
  int n_halts  = 0;
  int n_unlocks = 0;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** hop_lock_lbt_controller: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic bit model_active();
    return (m_mode >= hlc_pkg::MODE_NORMAL) && (m_mode <= hlc_pkg::MODE_PAIR_SLV) &&
           !m_halted;
  endfunction

  // Enter a lock phase and load its timer period
  function automatic void lock_to(logic [1:0] ph);
    case (ph)
      hlc_pkg::LS_FIRST: m_period = m_first_p;
      hlc_pkg::LS_LOCKED: begin
        m_countdown = m_timeout;
        m_period    = m_locked_p;
      end
      default: m_period = m_unlocked_p;
    endcase
    m_reload = 1'b1;
    m_phase  = ph;
  endfunction

  function automatic void hop_channel();
    m_chan = 7'((m_chan + HopStep) % ChanCount);
  endfunction

  // Advance the shadow controller by one event and return its status word
  function automatic hlc_pkg::out_t step_controller(hlc_pkg::in_t ev);
    hlc_pkg::out_t r;
    int            level;
    logic [2:0]    cmd;
    level    = -int'(ev.rssi_sample);
    cmd      = hlc_pkg::RC_NONE;
    m_period = '0;
    m_reload = 1'b0;
    if (model_active()) begin
      case (ev.action)
        hlc_pkg::ACT_TIMER: begin
          if (m_mode == hlc_pkg::MODE_NORMAL) begin
            if (m_phase == hlc_pkg::LS_FIRST) begin
              lock_to(hlc_pkg::LS_LOCKED);
            end else if (m_phase == hlc_pkg::LS_LOCKED) begin
              if (m_countdown <= 8'd1) begin
                m_countdown = '0;
                lock_to(hlc_pkg::LS_UNLOCKED);
                n_unlocks++;
              end else begin
                m_countdown = m_countdown - 8'd1;
              end
            end
            hop_channel();
            if (ev.tx_queue_nonempty) m_lbt_req = 1'b1;
            cmd = hlc_pkg::RC_RX_EN;
          end else if (m_mode == hlc_pkg::MODE_JAM || m_mode == hlc_pkg::MODE_PAIR_MST) begin
            hop_channel();
            lock_to(hlc_pkg::LS_LOCKED);
            if (m_mode == hlc_pkg::MODE_JAM) cmd = hlc_pkg::RC_TX_JAM;
            else cmd = hlc_pkg::RC_TX_PAIR;
          end else begin
            hop_channel();
            cmd = hlc_pkg::RC_RX_EN;
          end
        end
        hlc_pkg::ACT_RSSI: begin
          // Listen-before-talk decision on a pending request
          if (m_lbt_req) begin
            m_lbt_req = 1'b0;
            cmd = hlc_pkg::RC_STOP;
            if (level < int'(m_lbt_lim)) begin
              if (ev.tx_queue_nonempty) begin
                m_tx_frame = m_tx_frame + 32'd1;
                lock_to(hlc_pkg::LS_LOCKED);
                cmd = hlc_pkg::RC_TX_DATA;
                m_tx_cnt = m_tx_cnt + 32'd1;
              end
            end else begin
              m_skip_cnt = m_skip_cnt + 32'd1;
            end
          end
        end
        hlc_pkg::ACT_CRC_OK: begin
          if (m_mode == hlc_pkg::MODE_PAIR_SLV) begin
            if (ev.rssi_sample != 7'd0 && level > int'(m_pair_lim)) begin
              m_halted = 1'b1;
              cmd = hlc_pkg::RC_STOP;
              n_halts++;
            end
          end else if (m_mode == hlc_pkg::MODE_NORMAL) begin
            lock_to(hlc_pkg::LS_FIRST);
            m_lost_cnt = m_lost_cnt + (ev.rx_frame_number - (m_last_rx + 32'd1));
            m_last_rx  = ev.rx_frame_number;
            m_rx_cnt   = m_rx_cnt + 32'd1;
            if (ev.rx_queue_full) m_disc_cnt = m_disc_cnt + 32'd1;
          end
        end
        default: m_bad_cnt = m_bad_cnt + 32'd1;
      endcase
    end
    r.channel          = m_chan;
    r.radio_command    = cmd;
    r.reload_period    = m_reload ? m_period : 24'd0;
    r.period_reload    = m_reload;
    r.lock_state       = m_phase;
    r.tx_frame_number  = m_tx_frame;
    r.tx_count         = m_tx_cnt;
    r.lbt_skip_count   = m_skip_cnt;
    r.rx_count         = m_rx_cnt;
    r.rx_lost_count    = m_lost_cnt;
    r.rx_bad_crc_count = m_bad_cnt;
    r.rx_discard_count = m_disc_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    if (errors < PrintCap) $display("ERROR status #%0d: %s", checked, msg);
    errors++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Compare each status transaction with the oldest prediction
  always @(posedge clk) begin : check_status
    hlc_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_fifo.size() == 0) begin
        report_mismatch("status word with no event outstanding");
      end else begin
        want = status_fifo.pop_front();
        compare_field("channel", 32'(out_data.channel), 32'(want.channel));
        compare_field("radio_command", 32'(out_data.radio_command),
                      32'(want.radio_command));
        compare_field("reload_period", 32'(out_data.reload_period),
                      32'(want.reload_period));
        compare_field("period_reload", 32'(out_data.period_reload),
                      32'(want.period_reload));
        compare_field("lock_state", 32'(out_data.lock_state), 32'(want.lock_state));
        compare_field("tx_frame_number", out_data.tx_frame_number, want.tx_frame_number);
        compare_field("tx_count", out_data.tx_count, want.tx_count);
        compare_field("lbt_skip_count", out_data.lbt_skip_count, want.lbt_skip_count);
        compare_field("rx_count", out_data.rx_count, want.rx_count);
        compare_field("rx_lost_count", out_data.rx_lost_count, want.rx_lost_count);
        compare_field("rx_bad_crc_count", out_data.rx_bad_crc_count, want.rx_bad_crc_count);
        compare_field("rx_discard_count", out_data.rx_discard_count, want.rx_discard_count);
      end
      checked++;
    end
  end

  // ---------------------------------------------------------------- driving

  // Mostly short gaps, a few long ones; none in a calm stretch
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: long hold-off on request, random stalls otherwise outside calm stretches
  initial begin : status_sink
    int stall;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        stall = pick_gap();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic quiet_valid();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offer one event and predict its status at acceptance; leaves valid high
  task automatic send_event(hlc_pkg::in_t ev);
    int gap;
    gap = pick_gap();
    if (cfg_on) begin
      cfg_we <= 1'b0;
      cfg_on = 1'b0;
    end
    if (gap > 0) begin
      quiet_valid();
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    status_fifo.push_back(step_controller(ev));
    sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted status has arrived
  task automatic wait_drain();
    quiet_valid();
    if (cfg_on) begin
      cfg_we <= 1'b0;
      cfg_on = 1'b0;
    end
    while (status_fifo.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write; callers make sure the block is idle
  task automatic write_reg(logic [hlc_pkg::CfgIdxWidth-1:0] idx,
                           logic [hlc_pkg::CfgDataWidth-1:0] val);
    quiet_valid();
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (!cfg_on) cfg_we <= 1'b1;
    cfg_on = 1'b1;
    @(negedge clk);
    case (idx)
      hlc_pkg::CFG_MODE: begin
        m_mode   = val[2:0];
        m_halted = 1'b0;
        if (val[2:0] != hlc_pkg::MODE_OFF) m_phase = hlc_pkg::LS_UNLOCKED;
      end
      hlc_pkg::CFG_LOCKED_PERIOD: m_locked_p   = val;
      hlc_pkg::CFG_UNLOCK_PERIOD: m_unlocked_p = val;
      hlc_pkg::CFG_FIRST_PERIOD:  m_first_p    = val;
      hlc_pkg::CFG_LOCK_TIMEOUT:  m_timeout    = val[7:0];
      hlc_pkg::CFG_LBT_LIMIT:     m_lbt_lim    = val[7:0];
      hlc_pkg::CFG_PAIR_LIMIT:    m_pair_lim   = val[7:0];
      default: ;
    endcase
  endtask

  function automatic hlc_pkg::in_t make_event(hlc_pkg::action_e act, logic txq, logic full,
                                              logic [6:0] rssi, logic [31:0] frame);
    hlc_pkg::in_t ev;
    ev.action            = act;
    ev.tx_queue_nonempty = txq;
    ev.rx_queue_full     = full;
    ev.rssi_sample       = rssi;
    ev.rx_frame_number   = frame;
    return ev;
  endfunction

  // Random event; frame numbers mostly follow the last good frame
  function automatic hlc_pkg::in_t random_event();
    hlc_pkg::in_t ev;
    int           r;
    r = $urandom_range(0, 99);
    if (r < 35) ev.action = hlc_pkg::ACT_TIMER;
    else if (r < 62) ev.action = hlc_pkg::ACT_RSSI;
    else if (r < 85) ev.action = hlc_pkg::ACT_CRC_OK;
    else ev.action = hlc_pkg::ACT_CRC_ERR;
    ev.tx_queue_nonempty = ($urandom_range(0, 3) != 0);
    ev.rx_queue_full     = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 9);
    if (r == 0) ev.rssi_sample = 7'd0;
    else if (r == 1) ev.rssi_sample = 7'd127;
    else ev.rssi_sample = 7'($urandom_range(0, 127));
    r = $urandom_range(0, 99);
    if (r < 60) ev.rx_frame_number = m_last_rx + 32'd1;
    else if (r < 80) ev.rx_frame_number = m_last_rx + $urandom_range(2, 6);
    else if (r < 88) ev.rx_frame_number = m_last_rx;
    else ev.rx_frame_number = $urandom();
    return ev;
  endfunction

  // ---------------------------------------------------------------- tests

  // Idle after reset, then normal mode on default registers
  task automatic test_reset_defaults();
    send_event(make_event(hlc_pkg::ACT_TIMER, 1'b1, 1'b0, 7'd0, 32'd0));
    wait_drain();
    write_reg(hlc_pkg::CFG_MODE, 24'(hlc_pkg::MODE_NORMAL));
    // first frame after reset: gap from a last frame of zero wraps
    send_event(make_event(hlc_pkg::ACT_CRC_OK, 1'b1, 1'b1, 7'd127, 32'hFFFF_FFFF));
    send_event(make_event(hlc_pkg::ACT_TIMER, 1'b1, 1'b0, 7'd0, 32'd0));
    send_event(make_event(hlc_pkg::ACT_TIMER, 1'b0, 1'b1, 7'd64, 32'd0));
    // 0 dBm is not below the default limit: skipped
    send_event(make_event(hlc_pkg::ACT_RSSI, 1'b1, 1'b0, 7'd0, 32'd0));
    send_event(make_event(hlc_pkg::ACT_CRC_ERR, 1'b0, 1'b0, 7'd1, 32'd0));
  endtask

  // Pairing slave against the default -60 dBm limit, halt and release
  task automatic test_pairing_slave();
    wait_drain();
    write_reg(hlc_pkg::CFG_MODE, 24'(hlc_pkg::MODE_PAIR_SLV));
    send_event(make_event(hlc_pkg::ACT_CRC_OK, 1'b0, 1'b0, 7'd0, 32'd5));
    send_event(make_event(hlc_pkg::ACT_CRC_OK, 1'b0, 1'b0, 7'd60, 32'd6));
    send_event(make_event(hlc_pkg::ACT_CRC_OK, 1'b1, 1'b1, 7'd59, 32'd7));
    // halted: timer is ignored
    send_event(make_event(hlc_pkg::ACT_TIMER, 1'b1, 1'b0, 7'd10, 32'd0));
    wait_drain();
    write_reg(hlc_pkg::CFG_MODE, 24'(hlc_pkg::MODE_PAIR_SLV));
    send_event(make_event(hlc_pkg::ACT_TIMER, 1'b0, 1'b0, 7'd10, 32'd0));
  endtask

  // Jammer and pairing master lock on every hop
  task automatic test_jam_and_master();
    wait_drain();
    write_reg(hlc_pkg::CFG_LOCKED_PERIOD, 24'hFF_FFFF);
    write_reg(hlc_pkg::CFG_MODE, 24'(hlc_pkg::MODE_JAM));
    send_event(make_event(hlc_pkg::ACT_TIMER, 1'b0, 1'b0, 7'd0, 32'd0));
    send_event(make_event(hlc_pkg::ACT_CRC_OK, 1'b1, 1'b1, 7'd3, 32'hFFFF_FFFF));
    wait_drain();
    write_reg(hlc_pkg::CFG_MODE, 24'(hlc_pkg::MODE_PAIR_MST));
    send_event(make_event(hlc_pkg::ACT_TIMER, 1'b1, 1'b0, 7'd127, 32'd0));
    send_event(make_event(hlc_pkg::ACT_CRC_ERR, 1'b1, 1'b1, 7'd127, 32'hFFFF_FFFF));
  endtask

  // Listen-before-talk at both limit extremes
  task automatic test_listen_before_talk();
    wait_drain();
    write_reg(hlc_pkg::CFG_LBT_LIMIT, 24'd127);
    write_reg(hlc_pkg::CFG_UNLOCK_PERIOD, 24'h80_0001);
    write_reg(hlc_pkg::CFG_FIRST_PERIOD, 24'h7F_FFFE);
    write_reg(hlc_pkg::CFG_MODE, 24'(hlc_pkg::MODE_NORMAL));
    send_event(make_event(hlc_pkg::ACT_TIMER, 1'b1, 1'b0, 7'd0, 32'd0));
    send_event(make_event(hlc_pkg::ACT_RSSI, 1'b1, 1'b0, 7'd127, 32'd0));
    // quiet channel but nothing queued: stop without counting
    send_event(make_event(hlc_pkg::ACT_TIMER, 1'b1, 1'b0, 7'd0, 32'd0));
    send_event(make_event(hlc_pkg::ACT_RSSI, 1'b0, 1'b0, 7'd5, 32'd0));
    // no request pending: no effect
    send_event(make_event(hlc_pkg::ACT_RSSI, 1'b1, 1'b0, 7'd5, 32'd0));
    wait_drain();
    write_reg(hlc_pkg::CFG_LBT_LIMIT, 24'h00_0080);
    send_event(make_event(hlc_pkg::ACT_TIMER, 1'b1, 1'b0, 7'd0, 32'd0));
    send_event(make_event(hlc_pkg::ACT_RSSI, 1'b1, 1'b0, 7'd127, 32'd0));
    send_event(make_event(hlc_pkg::ACT_CRC_OK, 1'b0, 1'b0, 7'd1, 32'd0));
  endtask

  // Receiver holds off while events keep coming, then everything drains
  task automatic test_output_backpressure();
    wait_drain();
    calm = 1'b1;
    rx_hold = 300;
    repeat (24) send_event(random_event());
    calm = 1'b0;
    wait_drain();
  endtask

  // Random event streams over a sequence of register settings
  task automatic test_random_phases();
    logic signed [7:0] lim;
    logic [2:0]        mode;
    int                useful;
    int                tries;
    hlc_pkg::in_t      ev;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0, 1, 4, 6, 9: mode = hlc_pkg::MODE_NORMAL;
        2, 7, 11:      mode = hlc_pkg::MODE_PAIR_SLV;
        3, 10:         mode = hlc_pkg::MODE_JAM;
        5:             mode = hlc_pkg::MODE_PAIR_MST;
        default:       mode = hlc_pkg::MODE_OFF;
      endcase
      wait_drain();
      if (ph == 2) begin
        write_reg(hlc_pkg::CFG_LOCKED_PERIOD, 24'hFF_FFFF);
        write_reg(hlc_pkg::CFG_UNLOCK_PERIOD, 24'hFF_FFFF);
        write_reg(hlc_pkg::CFG_FIRST_PERIOD, 24'hFF_FFFF);
      end else if (ph == 5) begin
        write_reg(hlc_pkg::CFG_LOCKED_PERIOD, 24'd0);
        write_reg(hlc_pkg::CFG_UNLOCK_PERIOD, 24'd0);
        write_reg(hlc_pkg::CFG_FIRST_PERIOD, 24'd0);
      end else begin
        write_reg(hlc_pkg::CFG_LOCKED_PERIOD, 24'($urandom()));
        write_reg(hlc_pkg::CFG_UNLOCK_PERIOD, 24'($urandom()));
        write_reg(hlc_pkg::CFG_FIRST_PERIOD, 24'($urandom()));
      end
      // first phase keeps the reset timeout of 10 periods
      if (ph % 4 == 1) write_reg(hlc_pkg::CFG_LOCK_TIMEOUT, 24'd1);
      else if (ph == 6) write_reg(hlc_pkg::CFG_LOCK_TIMEOUT, 24'd255);
      else if (ph != 0) write_reg(hlc_pkg::CFG_LOCK_TIMEOUT, 24'($urandom_range(2, 6)));
      if (ph == 1) lim = 8'sh80;
      else if (ph == 2) lim = 8'sd127;
      else lim = 8'(-int'($urandom_range(0, 120)));
      write_reg(hlc_pkg::CFG_LBT_LIMIT, {16'd0, lim});
      if (ph == 7) lim = 8'sd127;
      else if (ph == 11) lim = 8'sh80;
      else lim = 8'(-int'($urandom_range(10, 100)));
      write_reg(hlc_pkg::CFG_PAIR_LIMIT, {16'd0, lim});
      write_reg(hlc_pkg::CFG_MODE, 24'(mode));
      calm = (ph % 5 == 3);
      useful = 0;
      tries  = 0;
      while (useful < PhaseEvents && tries < 3 * PhaseEvents) begin
        // release a halted slave now and then
        if (m_mode == hlc_pkg::MODE_PAIR_SLV && m_halted && $urandom_range(0, 3) == 0) begin
          wait_drain();
          write_reg(hlc_pkg::CFG_MODE, 24'(hlc_pkg::MODE_PAIR_SLV));
        end
        if (m_mode == hlc_pkg::MODE_NORMAL && $urandom_range(0, 2) == 0) begin
          // timer with a queued frame, then the RSSI measurement
          ev = random_event();
          ev.action = hlc_pkg::ACT_TIMER;
          ev.tx_queue_nonempty = 1'b1;
          send_event(ev);
          ev = random_event();
          ev.action = hlc_pkg::ACT_RSSI;
          send_event(ev);
          useful += 2;
          tries  += 2;
        end else begin
          if (model_active()) useful++;
          send_event(random_event());
          tries++;
        end
      end
      calm = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_pairing_slave();
    test_jam_and_master();
    test_listen_before_talk();
    test_output_backpressure();
    test_random_phases();
    wait_drain();
    repeat (8) @(posedge clk);
    if (status_fifo.size() != 0) report_mismatch("predicted status words never arrived");
    $display("Checked %0d status words for %0d events: idle, normal, jammer and pairing modes,",
             checked, sent);
    $display("register extremes, %0d pairing halts, %0d lock timeouts, output back-pressure.",
             n_halts, n_unlocks);
    if (errors == 0) begin
      $display("** hop_lock_lbt_controller: PASSED **");
    end else begin
      $display("** hop_lock_lbt_controller: FAILED **");
    end
    $finish;
  end

endmodule
